/* rtl/sac_pkg.sv */
// shared types and constants for the set-associative cache lru model
package sac_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int ADDR_W           = 64;
    localparam int CNT_W            = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_STORE  = 2'd1,
        FUNC_MODIFY = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic upd;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

/* rtl/sac_if.sv */
// request and result channel interfaces
interface sac_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic [sac_pkg::ADDR_W-1:0] address;

    modport source (output valid, output func, output address, input ready);
    modport sink (input valid, input func, input address, output ready);
endinterface

interface sac_res_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic                      miss;
    logic                      eviction;
    logic                      last;
    logic [sac_pkg::CNT_W-1:0] hits_total;
    logic [sac_pkg::CNT_W-1:0] misses_total;
    logic [sac_pkg::CNT_W-1:0] evictions_total;

    modport source (output valid, output hit, output miss, output eviction, output last,
                    output hits_total, output misses_total, output evictions_total,
                    input ready);
    modport sink (input valid, input hit, input miss, input eviction, input last,
                  input hits_total, input misses_total, input evictions_total,
                  output ready);
endinterface

/* rtl/sac_ctrl.sv */
// controller state machine sequencing the accesses of one request
module sac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_func,
    output logic              in_ready,
    input  sac_pkg::sts_t     sts,
    output sac_pkg::cmd_t     cmd
);
    import sac_pkg::*;

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && func_t'(in_func) != FUNC_NONE)
                begin
                    cmd.load    = 1'b1;
                    second_next = (func_t'(in_func) == FUNC_MODIFY);
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.upd  = 1'b1;
                    cmd.last = !second_reg;
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_UPDATE)
        else $error("read not followed by update");
    a_second_reads_again: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd && second_reg |=> state_reg == ST_READ && !second_reg)
        else $error("second access of modify lost");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("request taken while busy");
`endif
endmodule

/* rtl/sac_dp.sv */
// datapath: config, line store, lookup, lru ranks, counters and result register
module sac_dp #(
    parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sac_pkg::DEF_MAX_WAYS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [sac_pkg::ADDR_W-1:0]     in_address,
    input  sac_pkg::cmd_t                  cmd,
    output sac_pkg::sts_t                  sts,
    sac_res_if.source                      res
);
    import sac_pkg::*;

    localparam int NSETS   = 1 << MAX_SET_BITS;
    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W  = WAY_W;
    localparam int TAG_HI  = ADDR_W + RANK_W - 1;
    localparam int VLD_BIT = ADDR_W + RANK_W;
    localparam int LINE_W  = ADDR_W + RANK_W + 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] block_bits_reg;

    logic [SET_W-1:0]  set_reg;
    logic [ADDR_W-1:0] tag_reg;
    logic [SET_W-1:0]  clr_idx_reg;
    logic [MAX_WAYS-1:0][LINE_W-1:0] row_reg;
    logic [MAX_WAYS-1:0][LINE_W-1:0] mem [NSETS];

    logic [CNT_W-1:0] hits_reg, misses_reg, evicts_reg;
    logic [CNT_W-1:0] hits_next, misses_next, evicts_next;

    logic                            out_valid_reg;
    logic                            found, evict;
    logic [MAX_WAYS-1:0][LINE_W-1:0] row_next;
    logic [SET_W-1:0]                wr_addr;
    logic [MAX_WAYS-1:0][LINE_W-1:0] wr_row;

    // address split
    logic [3:0]        sb;
    logic [6:0]        shamt;
    logic [ADDR_W-1:0] shifted;
    logic [SET_W-1:0]  set_mask;

    always_comb
    begin
        sb       = (int'(set_bits_reg) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_reg};
        shamt    = 7'(sb) + 7'(block_bits_reg);
        shifted  = in_address >> block_bits_reg;
        set_mask = SET_W'((SET_W+1)'(1) << sb) - SET_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd0;
            ways_reg       <= 4'd1;
            block_bits_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_WAYS:       ways_reg       <= cfg_data[3:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // clearing pass over all set rows after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_idx_reg <= '0;
        else if (cmd.clr)
            clr_idx_reg <= clr_idx_reg + SET_W'(1);
    end

    assign wr_addr = cmd.clr ? clr_idx_reg : set_reg;
    assign wr_row  = cmd.clr ? '0 : row_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg <= shifted[SET_W-1:0] & set_mask;
            tag_reg <= (shamt >= 7'd64) ? '0 : (in_address >> shamt);
        end
        if (cmd.rd)
            row_reg <= mem[set_reg];
        if (cmd.upd || cmd.clr)
            mem[wr_addr] <= wr_row;
    end

    // lookup, victim choice and rank upkeep
    always_comb
    begin
        int                nw;
        logic [MAX_WAYS-1:0] inuse;
        logic [MAX_WAYS-1:0] vrow;
        logic              have_free;
        logic [WAY_W-1:0]  way;
        logic [RANK_W-1:0] best, r, rk;
        logic              was_valid;
        nw        = (ways_reg == 4'd0) ? 1 : ((int'(ways_reg) > MAX_WAYS) ? MAX_WAYS
                                                                       : int'(ways_reg));
        found     = 1'b0;
        have_free = 1'b0;
        way       = '0;
        best      = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            inuse[i] = (i < nw);
            vrow[i]  = row_reg[i][VLD_BIT];
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (inuse[i] && vrow[i] && row_reg[i][TAG_HI:RANK_W] == tag_reg)
            begin
                found = 1'b1;
                way   = WAY_W'(i);
            end
        end
        if (!found)
        begin
            for (int i = MAX_WAYS - 1; i >= 0; i--)
            begin
                if (inuse[i] && !vrow[i])
                begin
                    have_free = 1'b1;
                    way       = WAY_W'(i);
                end
            end
            if (!have_free)
            begin
                for (int i = 0; i < MAX_WAYS; i++)
                begin
                    if (inuse[i] && row_reg[i][RANK_W-1:0] > best)
                    begin
                        best = row_reg[i][RANK_W-1:0];
                        way  = WAY_W'(i);
                    end
                end
            end
        end
        evict     = !found && !have_free;
        was_valid = vrow[way];
        r         = row_reg[way][RANK_W-1:0];
        row_next  = row_reg;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            rk = row_reg[i][RANK_W-1:0];
            if (WAY_W'(i) == way)
            begin
                row_next[i][RANK_W-1:0] = '0;
                row_next[i][VLD_BIT]    = 1'b1;
                if (!found)
                    row_next[i][TAG_HI:RANK_W] = tag_reg;
            end
            else if (inuse[i] && vrow[i] && (!was_valid || rk < r) && rk < RANK_MAX)
            begin
                row_next[i][RANK_W-1:0] = rk + RANK_W'(1);
            end
        end
        hits_next   = (found && hits_reg != '1) ? hits_reg + CNT_W'(1) : hits_reg;
        misses_next = (!found && misses_reg != '1) ? misses_reg + CNT_W'(1) : misses_reg;
        evicts_next = (evict && evicts_reg != '1) ? evicts_reg + CNT_W'(1) : evicts_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd)
            begin
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                evicts_reg    <= evicts_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            res.hit             <= found;
            res.miss            <= !found;
            res.eviction        <= evict;
            res.last            <= cmd.last;
            res.hits_total      <= hits_next;
            res.misses_total    <= misses_next;
            res.evictions_total <= evicts_next;
        end
    end

    assign res.valid    = out_valid_reg;
    assign sts.out_free = !out_valid_reg || res.ready;
    assign sts.clr_last = (clr_idx_reg == SET_W'(NSETS - 1));

`ifndef NO_ASSERTIONS
    a_upd_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> res.valid)
        else $error("update without result");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> !out_valid_reg || res.ready)
        else $error("pending result overwritten");
    a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.hit != res.miss) && !(res.eviction && res.hit))
        else $error("inconsistent result flags");
    a_counts_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> (hits_reg + misses_reg) != (CNT_W'(0)) || $past(hits_reg) == '1)
        else $error("counters did not advance");
`endif
endmodule

/* rtl/set_assoc_cache_lru_model.sv */
// top level of the set-associative cache lru model
//
// req channel: one memory access per request (func, address), taken on
// valid && ready. func load or store gives one result, modify gives two
// results with last set on the second, the unused code is dropped.
// res channel: hit, miss, eviction, last and the saturating running totals.
// cfg port: write enable, index and data. the user must see that the port is
// written only while the block idles; the block itself does not enforce it.
// a request is taken in the idle state, then each access reads its set row
// from the line store in the read state and updates it in the update state,
// where it waits until the result register is free; a load or store makes
// one such access, a modify two. the read and write of the single-port set
// row memory bound the rate. a held result does not stop the next request
// from being taken. reset clears the configuration to one set, one way, no
// offset bits, and the totals; then a clearing pass writes every one of the
// 2^MAX_SET_BITS set rows (64 by default) to zero, one row a cycle, with
// req.ready low.
module set_assoc_cache_lru_model #(
    parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sac_pkg::DEF_MAX_WAYS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
    sac_req_if.sink                        req,
    sac_res_if.source                      res
);
    import sac_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_func  (req.func),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sac_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_address (req.address),
        .cmd        (cmd),
        .sts        (sts),
        .res        (res)
    );
endmodule
